// ===== rtl/dtt_pkg.sv =====
// Shared types, codes and helpers for the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int CPU_ID_BITS = 8;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 64;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [CPU_ID_BITS-1:0] cpu_t;
    typedef logic [TIME_W-1:0]      time_t;

    localparam logic [2:0] CMD_SET    = 3'd0;
    localparam logic [2:0] CMD_RESET  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [1:0] TS_INACTIVE  = 2'd0;
    localparam logic [1:0] TS_ACTIVE    = 2'd1;
    localparam logic [1:0] TS_SIGNALLED = 2'd2;

    localparam logic [2:0] MODE_WAIT_ALL = 3'd0;
    localparam logic [2:0] MODE_WAIT_ONE = 3'd1;
    localparam logic [2:0] MODE_CALLBACK = 3'd3;
    localparam logic [2:0] MODE_NONE     = 3'd4;

    localparam logic [1:0] TK_ALL_CPUS = 2'd2;
    localparam logic [1:0] TK_REQ_CPU  = 2'd1;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_WAS_ACTIVE = 2'd1;
    localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_WAKE_ONE = 2'd1;
    localparam logic [1:0] ACT_WAKE_ALL = 2'd2;
    localparam logic [1:0] ACT_CALLBACK = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN_CHK,
        ST_SCAN_MIN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        time_t      deadline;
        logic [1:0] tstate;
        logic [2:0] mode;
        cpu_t       cb_cpu;
        logic       cb_all;
        logic       cb_lsync;
        logic       cb_wait;
    } entry_t;

    typedef struct packed {
        logic   en;
        logic   dl_en;
        logic   cfg_en;
        idx_t   idx;
        entry_t entry;
    } wr_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] result_timer;
        logic [1:0] status;
        logic [1:0] action;
        logic [7:0] action_cpu;
        logic       action_all_cpus;
        logic       action_local_sync;
        logic       action_wait;
        time_t      delay_ns;
        logic       last;
    } res_t;

    function automatic logic [1:0] expiry_action(input logic [2:0] mode);
        logic [1:0] act;
        act = ACT_NONE;
        if (mode == MODE_WAIT_ONE) act = ACT_WAKE_ONE;
        else if (mode == MODE_WAIT_ALL) act = ACT_WAKE_ALL;
        else if (mode == MODE_CALLBACK) act = ACT_CALLBACK;
        return act;
    endfunction

    function automatic logic [1:0] cancel_action(input logic [2:0] mode);
        logic [1:0] act;
        act = ACT_NONE;
        if (mode == MODE_WAIT_ALL) act = ACT_WAKE_ALL;
        else if (mode == MODE_WAIT_ONE) act = ACT_WAKE_ONE;
        return act;
    endfunction

endpackage

// ===== rtl/dtt_alu.sv =====
// Shared 64-bit add/subtract unit; borrow flags a < b on subtract.
`timescale 1ns / 1ps
module dtt_alu
    import dtt_pkg::*;
(
    input  time_t a,
    input  time_t b,
    input  logic  sub,
    output time_t res,
    output logic  borrow
);

    logic [TIME_W:0] sum;

    assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TIME_W{1'b0}}, sub};
    assign res    = sum[TIME_W-1:0];
    assign borrow = sub & ~sum[TIME_W];

endmodule

// ===== rtl/dtt_store.sv =====
// Timer entry table: one read port, one write port.
`timescale 1ns / 1ps
module dtt_store
    import dtt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  idx_t   rd_idx,
    output entry_t rd_entry,
    input  wr_t    wr
);

    entry_t ent_reg [TIMER_COUNT];

    assign rd_entry = ent_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
                ent_reg[i].deadline <= '0;
                ent_reg[i].tstate   <= TS_INACTIVE;
                ent_reg[i].mode     <= MODE_NONE;
                ent_reg[i].cb_cpu   <= '0;
                ent_reg[i].cb_all   <= 1'b0;
                ent_reg[i].cb_lsync <= 1'b0;
                ent_reg[i].cb_wait  <= 1'b0;
            end
        end else if (wr.en) begin
            ent_reg[wr.idx].tstate <= wr.entry.tstate;
            if (wr.dl_en) begin
                ent_reg[wr.idx].deadline <= wr.entry.deadline;
            end
            if (wr.cfg_en) begin
                ent_reg[wr.idx].mode     <= wr.entry.mode;
                ent_reg[wr.idx].cb_cpu   <= wr.entry.cb_cpu;
                ent_reg[wr.idx].cb_all   <= wr.entry.cb_all;
                ent_reg[wr.idx].cb_lsync <= wr.entry.cb_lsync;
                ent_reg[wr.idx].cb_wait  <= wr.entry.cb_wait;
            end
        end
    end

endmodule

// ===== rtl/deadline_timer_table.sv =====
// Deadline timer table top level: sequencer, shared adder, entry table, result register.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | cmd, index, times, mode, callback target, cpu
//   m_      | out       | m_valid / m_ready  | kind, timer, status, action, delay, last
//
// A command moves to ST_CMD and writes its ack into the result register once that
// register is free. A tick from cpu 0 makes one pass over the table through the
// single adder, a second adder pass for each active entry not yet due, which
// competes for the earliest deadline, then reports; a tick from another cpu goes
// straight to the report. A full result register stalls the sequencer in place.
// Reset clears the table and sequencer.
`timescale 1ns / 1ps
module deadline_timer_table
    import dtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [3:0]  s_timer_index,
    input  logic [63:0] s_now_ns,
    input  logic [63:0] s_offset_ns,
    input  logic [2:0]  s_wake_mode,
    input  logic        s_callback_wait,
    input  logic        s_local_sync,
    input  logic [7:0]  s_target_cpu,
    input  logic [1:0]  s_target_kind,
    input  logic [7:0]  s_cpu_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [3:0]  m_result_timer,
    output logic [1:0]  m_status,
    output logic [1:0]  m_action,
    output logic [7:0]  m_action_cpu,
    output logic        m_action_all_cpus,
    output logic        m_action_local_sync,
    output logic        m_action_wait,
    output logic [63:0] m_delay_ns,
    output logic        m_last
);

    state_t     state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    time_t      earliest_reg, earliest_next;
    logic       far_reg, far_next;
    logic       m_valid_reg, m_valid_next;
    res_t       out_reg, out_next;

    logic [2:0] cmd_reg;
    logic [3:0] tidx_reg;
    time_t      now_reg, off_reg;
    logic [2:0] mode_reg;
    logic       cwait_reg, lsync_reg;
    cpu_t       tcpu_reg, mycpu_reg;
    logic [1:0] tkind_reg;

    idx_t       rd_idx;
    entry_t     rd_entry;
    wr_t        wr;
    time_t      alu_a, alu_b, alu_res;
    logic       alu_sub, alu_borrow;

    logic       out_free, accept, emit;
    logic       scan_done, is_active, cmd_ok;

    dtt_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    dtt_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign out_free  = ~m_valid_reg | m_ready;
    assign scan_done = (cnt_reg == CNT_W'(TIMER_COUNT));
    assign is_active = (rd_entry.tstate == TS_ACTIVE);
    assign cmd_ok    = (cmd_reg <= CMD_CANCEL) && (32'(tidx_reg) < TIMER_COUNT);
    assign rd_idx    = (state_reg == ST_CMD) ? idx_t'(tidx_reg) : cnt_reg[IDX_W-1:0];

    assign m_valid             = m_valid_reg;
    assign m_result_kind       = out_reg.result_kind;
    assign m_result_timer      = out_reg.result_timer;
    assign m_status            = out_reg.status;
    assign m_action            = out_reg.action;
    assign m_action_cpu        = out_reg.action_cpu;
    assign m_action_all_cpus   = out_reg.action_all_cpus;
    assign m_action_local_sync = out_reg.action_local_sync;
    assign m_action_wait       = out_reg.action_wait;
    assign m_delay_ns          = out_reg.delay_ns;
    assign m_last              = out_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        earliest_reg <= earliest_next;
        far_reg      <= far_next;
        out_reg      <= out_next;
        if (accept) begin
            cmd_reg   <= s_cmd;
            tidx_reg  <= s_timer_index;
            now_reg   <= s_now_ns;
            off_reg   <= s_offset_ns;
            mode_reg  <= s_wake_mode;
            cwait_reg <= s_callback_wait;
            lsync_reg <= s_local_sync;
            tcpu_reg  <= cpu_t'(s_target_cpu);
            tkind_reg <= s_target_kind;
            mycpu_reg <= cpu_t'(s_cpu_id);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_TICK && cpu_t'(s_cpu_id) == '0) state_next = ST_SCAN_CHK;
                    else if (s_cmd == CMD_TICK) state_next = ST_REPORT;
                    else state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_SCAN_CHK: begin
                if (scan_done) state_next = ST_REPORT;
                else if (is_active && alu_borrow) state_next = ST_SCAN_MIN;
            end
            ST_SCAN_MIN: state_next = ST_SCAN_CHK;
            ST_REPORT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and result load
    always_comb begin
        cnt_next      = cnt_reg;
        earliest_next = earliest_reg;
        far_next      = far_reg;
        out_next      = out_reg;
        emit          = 1'b0;
        wr            = '0;
        wr.idx        = rd_idx;
        wr.entry      = rd_entry;
        alu_a         = now_reg;
        alu_b         = rd_entry.deadline;
        alu_sub       = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                cnt_next      = '0;
                earliest_next = '1;
                far_next      = (s_cpu_id != 8'd0) && (cpu_t'(s_cpu_id) != '0);
            end
            ST_CMD: begin
                alu_a   = now_reg;
                alu_b   = off_reg;
                alu_sub = 1'b0;
                emit    = out_free;
                out_next              = '0;
                out_next.result_kind  = KIND_ACK;
                out_next.result_timer = tidx_reg;
                out_next.last         = 1'b1;
                if (!cmd_ok) begin
                    out_next.status = STAT_NOT_ACTIVE;
                end else begin
                    wr.en = out_free;
                    unique case (cmd_reg)
                        CMD_SET, CMD_RESET: begin
                            out_next.status   = is_active ? STAT_WAS_ACTIVE : STAT_OK;
                            wr.dl_en          = 1'b1;
                            wr.cfg_en         = (cmd_reg == CMD_SET);
                            wr.entry.tstate   = TS_INACTIVE;
                            wr.entry.deadline = alu_res;
                            wr.entry.mode     = mode_reg;
                            wr.entry.cb_wait  = cwait_reg;
                            wr.entry.cb_lsync = lsync_reg;
                            wr.entry.cb_all   = (tkind_reg == TK_ALL_CPUS);
                            if (tkind_reg == TK_ALL_CPUS) wr.entry.cb_cpu = '0;
                            else if (tkind_reg == TK_REQ_CPU) wr.entry.cb_cpu = mycpu_reg;
                            else wr.entry.cb_cpu = tcpu_reg;
                        end
                        CMD_START: begin
                            out_next.status = is_active ? STAT_WAS_ACTIVE : STAT_OK;
                            wr.entry.tstate = TS_ACTIVE;
                        end
                        default: begin
                            if (is_active) begin
                                wr.entry.tstate = TS_SIGNALLED;
                                out_next.action = cancel_action(rd_entry.mode);
                            end else begin
                                wr.entry.tstate = TS_INACTIVE;
                                out_next.status = STAT_NOT_ACTIVE;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN_CHK: begin
                if (!scan_done) begin
                    if (is_active && !alu_borrow) begin
                        emit = out_free;
                        wr.en = out_free;
                        wr.entry.tstate = TS_SIGNALLED;
                        out_next              = '0;
                        out_next.result_kind  = KIND_EXPIRY;
                        out_next.result_timer = 4'(cnt_reg[IDX_W-1:0]);
                        out_next.status       = STAT_OK;
                        out_next.action       = expiry_action(rd_entry.mode);
                        if (expiry_action(rd_entry.mode) == ACT_CALLBACK) begin
                            out_next.action_cpu        = rd_entry.cb_all ? 8'd0 : 8'(rd_entry.cb_cpu);
                            out_next.action_all_cpus   = rd_entry.cb_all;
                            out_next.action_local_sync = rd_entry.cb_lsync;
                            out_next.action_wait       = rd_entry.cb_wait;
                        end
                        if (out_free) cnt_next = cnt_reg + 1'b1;
                    end else if (!is_active) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_SCAN_MIN: begin
                alu_a = rd_entry.deadline;
                alu_b = earliest_reg;
                if (alu_borrow) earliest_next = rd_entry.deadline;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_REPORT: begin
                alu_a = earliest_reg;
                alu_b = now_reg;
                emit  = out_free;
                out_next             = '0;
                out_next.result_kind = KIND_REPORT;
                out_next.last        = 1'b1;
                if (far_reg) out_next.delay_ns = '1;
                else if (!alu_borrow) out_next.delay_ns = alu_res;
            end
            default: ;
        endcase

        if (!emit) out_next = out_reg;
        m_valid_next = emit | (m_valid_reg & ~m_ready);
    end

endmodule
